@@ rtl/vwma_pkg.sv @@
// Shared constants, types and request structs for the moving average block.
`timescale 1ns / 1ps
package vwma_pkg;

  // Ring capacity and sample width
  localparam int MAX_WINDOW  = 128;
  localparam int SAMPLE_BITS = 16;

  // Window register
  localparam int WIN_W = 8;

  // Derived widths
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = SAMPLE_BITS + CNT_W;
  localparam int DIV_STEP_W = $clog2(SUM_W + 1);
  localparam int CMP_W      = (CNT_W > WIN_W) ? CNT_W : WIN_W;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [WIN_W-1:0]       win_t;
  typedef logic        [IDX_W-1:0]       idx_t;
  typedef logic        [CNT_W-1:0]       cnt_t;
  typedef logic        [CNT_W:0]         pos_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic        [SUM_W-1:0]       mag_t;
  typedef logic        [CMP_W-1:0]       cmp_t;
  typedef logic        [DIV_STEP_W-1:0]  step_t;

  localparam win_t WIN_RESET = win_t'(20);

  // Divider start request
  typedef struct packed {
    logic start;
    mag_t dividend;
    cnt_t divisor;
  } div_cmd_t;

  // Divider result
  typedef struct packed {
    logic done;
    mag_t quotient;
  } div_rsp_t;

endpackage

@@ rtl/vwma_in_if.sv @@
// Input sample channel.
`timescale 1ns / 1ps
interface vwma_in_if;
  logic             valid;
  logic             ready;
  vwma_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

@@ rtl/vwma_out_if.sv @@
// Result channel carrying the average.
`timescale 1ns / 1ps
interface vwma_out_if;
  logic             valid;
  logic             ready;
  vwma_pkg::sample_t average_out;

  modport source (output valid, output average_out, input ready);
  modport sink   (input valid, input average_out, output ready);
endinterface

@@ rtl/vwma_cfg_if.sv @@
// Configuration write channel for the window length register.
`timescale 1ns / 1ps
interface vwma_cfg_if;
  logic           valid;
  logic           ready;
  vwma_pkg::win_t window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

@@ rtl/vwma_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module vwma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/vwma_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module vwma_div (
  input  logic               clk,
  input  logic               rst_n,
  input  vwma_pkg::div_cmd_t cmd,
  output vwma_pkg::div_rsp_t rsp
);

  vwma_pkg::mag_t  dvd_r, dvd_nxt;
  vwma_pkg::cnt_t  dsr_r, dsr_nxt;
  vwma_pkg::cnt_t  rem_r, rem_nxt;
  vwma_pkg::step_t step_r, step_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;

  logic [vwma_pkg::CNT_W:0] rem_shift;
  logic [vwma_pkg::CNT_W:0] rem_diff;
  logic                     ge;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    rem_shift = {rem_r, dvd_r[vwma_pkg::SUM_W-1]};
    rem_diff  = rem_shift - {1'b0, dsr_r};
    ge        = (rem_shift >= {1'b0, dsr_r});
  end

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      dvd_nxt  = cmd.dividend;
      dsr_nxt  = cmd.divisor;
      rem_nxt  = '0;
      step_nxt = vwma_pkg::step_t'(vwma_pkg::SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? rem_diff[vwma_pkg::CNT_W-1:0] : rem_shift[vwma_pkg::CNT_W-1:0];
      dvd_nxt  = {dvd_r[vwma_pkg::SUM_W-2:0], ge};
      step_nxt = step_r - vwma_pkg::step_t'(1);
      if (step_r == vwma_pkg::step_t'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

@@ rtl/variable_window_moving_average.sv @@
// Variable window boxcar moving average: ring memory, running sum, divider.
`timescale 1ns / 1ps
// Sequence per sample: accept, ring update, divider launch, 24 divider steps,
//   done, result load; an empty ring skips the divider and loads a zero result.
// Samples are taken one at a time: a new request is accepted only in idle,
//   once the previous result is loaded; the bit-serial divider over the
//   24-bit sum sets the pace. A stalled result holds the sequencer until it drains.
// Reset (rst_n, synchronous): sum, fill count and ring pointer clear, window
//   returns to 20; ring contents stay undefined and are only read once written.
module variable_window_moving_average (
  input  logic      clk,
  input  logic      rst_n,
  vwma_in_if.sink   in_ch,
  vwma_out_if.source out_ch,
  vwma_cfg_if.sink  cfg_ch
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UPD    = 3'd1;
  localparam logic [2:0] ST_LAUNCH = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  // Ring update modes
  localparam logic [1:0] MODE_APPEND  = 2'd0;
  localparam logic [1:0] MODE_REPLACE = 2'd1;
  localparam logic [1:0] MODE_DROP    = 2'd2;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        mode_r, mode_nxt;
  vwma_pkg::win_t    win_r, win_nxt;
  vwma_pkg::sum_t    sum_r, sum_nxt;
  vwma_pkg::cnt_t    cnt_r, cnt_nxt;
  vwma_pkg::idx_t    oldest_r, oldest_nxt;
  vwma_pkg::idx_t    wr_addr_r, wr_addr_nxt;
  vwma_pkg::sample_t samp_r, samp_nxt;
  vwma_pkg::sample_t res_r, res_nxt;
  vwma_pkg::sample_t out_data_r, out_data_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              in_fire;
  vwma_pkg::cnt_t    w_eff;
  vwma_pkg::pos_t    pos_sum;
  vwma_pkg::idx_t    oldest_inc;
  vwma_pkg::sum_t    old_ext;
  vwma_pkg::sum_t    v_ext;
  vwma_pkg::mag_t    sum_mag;
  logic              ram_wr_en;
  logic [vwma_pkg::SAMPLE_BITS-1:0] ram_rd_data;

  vwma_pkg::div_cmd_t div_cmd;
  vwma_pkg::div_rsp_t div_rsp;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Clamp the window to the ring capacity
  always_comb begin
    if (vwma_pkg::cmp_t'(win_r) > vwma_pkg::cmp_t'(vwma_pkg::MAX_WINDOW)) begin
      w_eff = vwma_pkg::cnt_t'(vwma_pkg::MAX_WINDOW);
    end else begin
      w_eff = vwma_pkg::cnt_t'(win_r);
    end
  end

  // Append slot: oldest plus fill count, wrapped around the ring
  always_comb begin
    pos_sum = vwma_pkg::pos_t'(oldest_r) + vwma_pkg::pos_t'(cnt_r);
    if (pos_sum >= vwma_pkg::pos_t'(vwma_pkg::MAX_WINDOW)) begin
      pos_sum = pos_sum - vwma_pkg::pos_t'(vwma_pkg::MAX_WINDOW);
    end
  end

  assign oldest_inc = (oldest_r == vwma_pkg::idx_t'(vwma_pkg::MAX_WINDOW - 1)) ?
                      '0 : oldest_r + vwma_pkg::idx_t'(1);

  assign old_ext = vwma_pkg::sum_t'(vwma_pkg::sample_t'(ram_rd_data));
  assign v_ext   = vwma_pkg::sum_t'(samp_r);
  assign sum_mag = sum_r[vwma_pkg::SUM_W-1] ? vwma_pkg::mag_t'(-sum_r) :
                                              vwma_pkg::mag_t'(sum_r);

  // Start the divider on the new sum and count
  always_comb begin
    div_cmd.start    = (state_r == ST_LAUNCH) && (cnt_r != '0);
    div_cmd.dividend = sum_mag;
    div_cmd.divisor  = cnt_r;
  end

  assign ram_wr_en = (state_r == ST_UPD) && (mode_r != MODE_DROP);

  // Sequencer, ring bookkeeping and output register
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    win_nxt       = win_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    oldest_nxt    = oldest_r;
    wr_addr_nxt   = wr_addr_r;
    samp_nxt      = samp_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    if (cfg_ch.valid && cfg_ch.ready) begin
      win_nxt = cfg_ch.window_length;
    end

    // Drop a delivered result
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          samp_nxt    = in_ch.sample_in;
          wr_addr_nxt = pos_sum[vwma_pkg::IDX_W-1:0];
          if (cnt_r < w_eff) begin
            mode_nxt = MODE_APPEND;
          end else if (cnt_r == w_eff) begin
            mode_nxt = MODE_REPLACE;
          end else begin
            mode_nxt = MODE_DROP;
          end
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        case (mode_r)
          MODE_APPEND: begin
            sum_nxt = sum_r + v_ext;
            cnt_nxt = cnt_r + vwma_pkg::cnt_t'(1);
          end
          MODE_REPLACE: begin
            sum_nxt = sum_r + v_ext - old_ext;
            if (cnt_r != '0) begin
              oldest_nxt = oldest_inc;
            end
          end
          default: begin
            sum_nxt    = sum_r - old_ext;
            oldest_nxt = oldest_inc;
            cnt_nxt    = cnt_r - vwma_pkg::cnt_t'(1);
          end
        endcase
        // An empty ring holds a zero sum
        if (cnt_nxt == '0) begin
          sum_nxt = '0;
        end
        state_nxt = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        if (cnt_r == '0) begin
          res_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (sum_r[vwma_pkg::SUM_W-1]) begin
            res_nxt = vwma_pkg::sample_t'(-div_rsp.quotient);
          end else begin
            res_nxt = vwma_pkg::sample_t'(div_rsp.quotient);
          end
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= vwma_pkg::WIN_RESET;
      sum_r       <= '0;
      cnt_r       <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      oldest_r    <= oldest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    wr_addr_r  <= wr_addr_nxt;
    samp_r     <= samp_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Sample ring: read the oldest entry on request, write back during update except in drop mode
  vwma_ram #(
    .WIDTH (vwma_pkg::SAMPLE_BITS),
    .DEPTH (vwma_pkg::MAX_WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_addr_r),
    .wr_data (samp_r),
    .rd_en   (in_fire),
    .rd_addr (oldest_r),
    .rd_data (ram_rd_data)
  );

  vwma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .rsp   (div_rsp)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.average_out = out_data_r;

  // An accepted request always moves to the ring update next
  a_fire_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_UPD))
    else $error("request accepted but ring update skipped");

  // An empty ring never carries a sum
  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (sum_r == '0))
    else $error("nonzero sum with empty ring");

  // Fill count stays within the ring capacity
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= vwma_pkg::cnt_t'(vwma_pkg::MAX_WINDOW))
    else $error("fill count beyond ring capacity");

  // Divider completes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider result outside divide state");

endmodule
